[rtl/ckr_pkg.sv]
// ----------------------------------------------------------------------------
// ckr_pkg
// Shared types, constants and helpers for the ChaCha20 keystream generator.
// ----------------------------------------------------------------------------
package ckr_pkg;

  localparam int unsigned BlocksPerRefill = 16;
  localparam logic [23:0] ReseedDefault   = 24'd1600000;
  localparam int unsigned RekeyWords      = 10;
  localparam int unsigned SeedWords       = 10;

  // request kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_STIR    = 2'd1;
  localparam logic [1:0] KIND_RAW     = 2'd2;
  localparam logic [1:0] KIND_UNIFORM = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNSEED = 2'd1;
  localparam logic [1:0] ST_DUE    = 2'd2;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STIR,
    S_BLK_INIT,
    S_BLK_ROUND,
    S_BLK_WRITE,
    S_REKEY_RD,
    S_REKEY_WR,
    S_DRAW_RD,
    S_DRAW_WAIT,
    S_DRAW_USE,
    S_MOD,
    S_LIM,
    S_OUT
  } state_t;

  typedef logic [31:0] word_t;

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // one ChaCha quarter round
  function automatic logic [127:0] qr(input word_t a, input word_t b,
                                      input word_t c, input word_t d);
    word_t a1, b1, c1, d1;
    a1 = a + b;  d1 = rotl(d ^ a1, 16);
    c1 = c + d1; b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    qr = {a1, b1, c1, d1};
  endfunction

endpackage

[rtl/ckr_if.sv]
// ----------------------------------------------------------------------------
// ckr_req_if / ckr_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ckr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  seed_index;
  logic [31:0] seed_value;
  logic [31:0] bound;
  modport source (output valid, kind, seed_index, seed_value, bound, input ready);
  modport sink   (input valid, kind, seed_index, seed_value, bound, output ready);
endinterface

interface ckr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  logic [1:0]  status;
  modport source (output valid, random_word, status, input ready);
  modport sink   (input valid, random_word, status, output ready);
endinterface

[rtl/ckr_ram.sv]
// ----------------------------------------------------------------------------
// ckr_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ckr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/ckr_divider.sv]
// ----------------------------------------------------------------------------
// ckr_divider
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ckr_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  logic [31:0] rem;
  logic [31:0] dvd;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial     = {rem, dvd[31]} - {1'b0, dvs};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        // shift one bit in, subtract when it fits
        if (!trial[32]) rem <= trial[31:0];
        else            rem <= {rem[30:0], dvd[31]};
        dvd <= {dvd[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/chacha20_keystream_rng.sv]
// ----------------------------------------------------------------------------
// chacha20_keystream_rng
// ChaCha20 random generator with fast key erasure.
// ----------------------------------------------------------------------------
// One request at a time. A load, or a draw before seeding, goes straight to the
// output state; a raw draw reads its word from the buffer RAM, and a draw that
// finds the buffer empty first runs a refill of BLOCKS_PER_REFILL blocks. Each
// block has a setup step, 20 round steps (one column or diagonal round per cycle)
// and 16 RAM writes. After the last block, the key and nonce are rekeyed from the
// first ten buffer words, which are zeroed. A uniform draw adds two remainder
// passes from the shared iterative divider, and a rejected word repeats the draw.
// The keystream buffer lives in one RAM; the key and counter sit in registers.
module chacha20_keystream_rng #(
  parameter int unsigned BLOCKS_PER_REFILL = ckr_pkg::BlocksPerRefill
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  ckr_req_if.sink     req,
  ckr_rsp_if.source   rsp
);
  localparam int unsigned BufWords = BLOCKS_PER_REFILL * 16;
  localparam int unsigned AddrW    = $clog2(BufWords);
  localparam int unsigned LeftW    = $clog2(BufWords + 1);
  localparam int unsigned BlkW     = $clog2(BLOCKS_PER_REFILL + 1);
  localparam logic [LeftW-1:0] Refilled = LeftW'(BufWords - ckr_pkg::RekeyWords);

  ckr_pkg::state_t state, state_next;

  logic [23:0] reseed_limit;
  logic [31:0] key [8];
  logic [31:0] nonce [2];
  logic [63:0] counter;
  logic [31:0] seed_hold [ckr_pkg::SeedWords];
  logic [31:0] x [16];
  logic [LeftW-1:0] words_left;
  logic [23:0] budget;
  logic        seeded;
  logic        due;
  logic [1:0]  kind;
  logic [31:0] bound;
  logic [31:0] lim;
  logic [31:0] word;
  logic [1:0]  status;
  logic [4:0]  rnd;
  logic [4:0]  idx;
  logic [BlkW-1:0] blk;
  logic        draw_pend;
  logic        rsp_valid;

  // buffer RAM
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [31:0]      ram_wdata;
  logic [31:0]      ram_rdata;

  ckr_ram #(.Width(32), .Depth(BufWords)) u_buf (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // divider
  logic        div_start;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic        div_done;
  logic [31:0] div_rem;

  ckr_divider u_div (
    .clk, .rst, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .remainder(div_rem)
  );

  // initial block words
  logic [31:0] init_w [16];
  always_comb begin
    init_w[0] = ckr_pkg::Sigma0;
    init_w[1] = ckr_pkg::Sigma1;
    init_w[2] = ckr_pkg::Sigma2;
    init_w[3] = ckr_pkg::Sigma3;
    for (int i = 0; i < 8; i++) init_w[4+i] = key[i];
    init_w[12] = counter[31:0];
    init_w[13] = counter[63:32];
    init_w[14] = nonce[0];
    init_w[15] = nonce[1];
  end

  // one column or diagonal round
  logic [31:0] xr [16];
  always_comb begin
    logic [127:0] q0, q1, q2, q3;
    if (!rnd[0]) begin
      q0 = ckr_pkg::qr(x[0], x[4], x[8],  x[12]);
      q1 = ckr_pkg::qr(x[1], x[5], x[9],  x[13]);
      q2 = ckr_pkg::qr(x[2], x[6], x[10], x[14]);
      q3 = ckr_pkg::qr(x[3], x[7], x[11], x[15]);
      {xr[0], xr[4], xr[8],  xr[12]} = q0;
      {xr[1], xr[5], xr[9],  xr[13]} = q1;
      {xr[2], xr[6], xr[10], xr[14]} = q2;
      {xr[3], xr[7], xr[11], xr[15]} = q3;
    end else begin
      q0 = ckr_pkg::qr(x[0], x[5], x[10], x[15]);
      q1 = ckr_pkg::qr(x[1], x[6], x[11], x[12]);
      q2 = ckr_pkg::qr(x[2], x[7], x[8],  x[13]);
      q3 = ckr_pkg::qr(x[3], x[4], x[9],  x[14]);
      {xr[0], xr[5], xr[10], xr[15]} = q0;
      {xr[1], xr[6], xr[11], xr[12]} = q1;
      {xr[2], xr[7], xr[8],  xr[13]} = q2;
      {xr[3], xr[4], xr[9],  xr[14]} = q3;
    end
  end

  assign req.ready       = (state == ckr_pkg::S_IDLE) && !rsp_valid;
  assign rsp.valid       = rsp_valid;
  assign rsp.random_word = word;
  assign rsp.status      = status;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ckr_pkg::S_IDLE: begin
        if (req.valid && req.ready) begin
          case (req.kind)
            ckr_pkg::KIND_LOAD: state_next = ckr_pkg::S_OUT;
            ckr_pkg::KIND_STIR: state_next = ckr_pkg::S_STIR;
            ckr_pkg::KIND_RAW:
              state_next = seeded ? ckr_pkg::S_DRAW_RD : ckr_pkg::S_OUT;
            default: begin
              if (!seeded || req.bound < 32'd2) state_next = ckr_pkg::S_OUT;
              else state_next = ckr_pkg::S_LIM;
            end
          endcase
        end
      end
      ckr_pkg::S_STIR:     state_next = ckr_pkg::S_BLK_INIT;
      ckr_pkg::S_BLK_INIT: state_next = ckr_pkg::S_BLK_ROUND;
      ckr_pkg::S_BLK_ROUND:
        if (rnd == 5'd19) state_next = ckr_pkg::S_BLK_WRITE;
      ckr_pkg::S_BLK_WRITE:
        if (idx == 5'd15) begin
          if (blk == BlkW'(BLOCKS_PER_REFILL - 1)) state_next = ckr_pkg::S_REKEY_RD;
          else state_next = ckr_pkg::S_BLK_INIT;
        end
      ckr_pkg::S_REKEY_RD: state_next = ckr_pkg::S_REKEY_WR;
      ckr_pkg::S_REKEY_WR:
        if (idx == 5'd9) state_next = draw_pend ? ckr_pkg::S_DRAW_RD : ckr_pkg::S_OUT;
        else state_next = ckr_pkg::S_REKEY_RD;
      ckr_pkg::S_DRAW_RD:
        if (words_left == '0 || words_left > LeftW'(BufWords))
          state_next = ckr_pkg::S_BLK_INIT;
        else state_next = ckr_pkg::S_DRAW_WAIT;
      ckr_pkg::S_DRAW_WAIT: state_next = ckr_pkg::S_DRAW_USE;
      ckr_pkg::S_DRAW_USE: begin
        if (kind == ckr_pkg::KIND_RAW) state_next = ckr_pkg::S_OUT;
        else if (ram_rdata >= lim) state_next = ckr_pkg::S_MOD;
        else state_next = ckr_pkg::S_DRAW_RD;
      end
      ckr_pkg::S_MOD: if (div_done) state_next = ckr_pkg::S_OUT;
      ckr_pkg::S_LIM: if (div_done) state_next = ckr_pkg::S_DRAW_RD;
      ckr_pkg::S_OUT: state_next = ckr_pkg::S_IDLE;
      default:        state_next = ckr_pkg::S_IDLE;
    endcase
  end

  // RAM and divider controls
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = bound;
    case (state)
      ckr_pkg::S_BLK_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = AddrW'({blk, idx[3:0]});
        ram_wdata = x[idx[3:0]] + init_w[idx[3:0]];
      end
      ckr_pkg::S_REKEY_RD: ram_addr = AddrW'(idx);
      ckr_pkg::S_REKEY_WR: begin
        ram_we   = 1'b1;
        ram_addr = AddrW'(idx);
      end
      ckr_pkg::S_DRAW_RD: ram_addr = AddrW'(LeftW'(BufWords) - words_left);
      ckr_pkg::S_DRAW_WAIT: begin
        ram_we   = 1'b1;
        ram_addr = AddrW'(LeftW'(BufWords) - words_left);
      end
      ckr_pkg::S_DRAW_USE: begin
        div_start = (kind == ckr_pkg::KIND_UNIFORM) && (ram_rdata >= lim);
        div_a     = ram_rdata;
      end
      ckr_pkg::S_IDLE: begin
        // bound register loads on this same edge, so divide by the live bound
        div_start = req.valid && req.ready && req.kind == ckr_pkg::KIND_UNIFORM
                    && seeded && req.bound >= 32'd2;
        div_a     = 32'd0 - req.bound;
        div_b     = req.bound;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ckr_pkg::S_IDLE;
      reseed_limit <= ckr_pkg::ReseedDefault;
      for (int i = 0; i < 8; i++) key[i] <= '0;
      nonce[0]     <= '0;
      nonce[1]     <= '0;
      counter      <= '0;
      for (int i = 0; i < ckr_pkg::SeedWords; i++) seed_hold[i] <= '0;
      words_left   <= '0;
      budget       <= '0;
      seeded       <= 1'b0;
      rsp_valid    <= 1'b0;
      draw_pend    <= 1'b0;
      rnd          <= '0;
      idx          <= '0;
      blk          <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) reseed_limit <= cfg_wdata;
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      case (state)
        ckr_pkg::S_IDLE: begin
          if (req.valid && req.ready) begin
            kind   <= req.kind;
            bound  <= req.bound;
            word   <= '0;
            status <= ckr_pkg::ST_OK;
            due    <= 1'b0;
            blk    <= '0;
            if (req.kind == ckr_pkg::KIND_LOAD && req.seed_index < 4'd10)
              seed_hold[req.seed_index] <= req.seed_value;
            if (req.kind[1] && !seeded) status <= ckr_pkg::ST_UNSEED;
            draw_pend <= req.kind[1];
          end
        end
        ckr_pkg::S_STIR: begin
          if (!seeded) begin
            for (int i = 0; i < 8; i++) key[i] <= seed_hold[i];
            nonce[0] <= seed_hold[8];
            nonce[1] <= seed_hold[9];
            counter  <= '0;
          end else begin
            for (int i = 0; i < 8; i++) key[i] <= key[i] ^ seed_hold[i];
          end
          for (int i = 0; i < ckr_pkg::SeedWords; i++) seed_hold[i] <= '0;
          words_left <= '0;
          budget     <= reseed_limit;
          seeded     <= 1'b1;
          draw_pend  <= 1'b0;
        end
        ckr_pkg::S_BLK_INIT: begin
          for (int i = 0; i < 16; i++) x[i] <= init_w[i];
          rnd <= '0;
        end
        ckr_pkg::S_BLK_ROUND: begin
          for (int i = 0; i < 16; i++) x[i] <= xr[i];
          rnd <= rnd + 5'd1;
          idx <= '0;
        end
        ckr_pkg::S_BLK_WRITE: begin
          // last word of the last block hands idx to the rekey pass at zero
          if (idx == 5'd15 && blk == BlkW'(BLOCKS_PER_REFILL - 1)) idx <= '0;
          else idx <= idx + 5'd1;
          if (idx == 5'd15) begin
            counter <= counter + 64'd1;
            blk     <= blk + BlkW'(1);
          end
        end
        ckr_pkg::S_REKEY_WR: begin
          // ram_rdata holds buffer word idx; zeroed by this write
          if (idx < 5'd8) key[idx[2:0]] <= ram_rdata;
          else nonce[idx[0]] <= ram_rdata;
          idx <= idx + 5'd1;
          if (idx == 5'd9) begin
            counter    <= '0;
            words_left <= Refilled;
          end
        end
        ckr_pkg::S_DRAW_RD: begin
          blk <= '0;
          if (!(words_left == '0 || words_left > LeftW'(BufWords))) begin
            if (budget <= 24'd4) begin
              budget <= '0;
              due    <= 1'b1;
            end else begin
              budget <= budget - 24'd4;
            end
          end
        end
        ckr_pkg::S_DRAW_WAIT: words_left <= words_left - LeftW'(1);
        ckr_pkg::S_DRAW_USE: begin
          if (kind == ckr_pkg::KIND_RAW) word <= ram_rdata;
        end
        ckr_pkg::S_LIM: if (div_done) lim <= div_rem;
        ckr_pkg::S_MOD: if (div_done) word <= div_rem;
        ckr_pkg::S_OUT: begin
          rsp_valid <= 1'b1;
          if (due) status <= ckr_pkg::ST_DUE;
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/ckr_checker.sv]
// ----------------------------------------------------------------------------
// ckr_checker
// Port-level checks on the generator's request and result channels.
// ----------------------------------------------------------------------------
module ckr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_word,
  input logic [1:0]  rsp_status
);
  // a pending result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
    else $error("result changed while stalled");

  // no new request while a result waits
  a_one: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken with result pending");

  // status is one of the defined codes
  a_stat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ckr_pkg::ST_OK || rsp_status == ckr_pkg::ST_UNSEED ||
                   rsp_status == ckr_pkg::ST_DUE))
    else $error("bad status");

  // unseeded answers carry zero
  a_unseed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ckr_pkg::ST_UNSEED |-> rsp_word == 32'd0)
    else $error("unseeded answer nonzero");
endmodule

bind chacha20_keystream_rng ckr_checker u_ckr_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_word(rsp.random_word), .rsp_status(rsp.status)
);
